[hw/rtl/mva_pkg.sv]
// Shared constants, codes and types for the mesh vertex normal averager.
package mva_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_FACES    = 8192;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = VIDX_W + 1;
    localparam int FIDX_W  = $clog2(MAX_FACES);
    localparam int FCNT_W  = FIDX_W + 1;

    localparam int FUNC_W   = 3;
    localparam int COORD_W  = 32;
    localparam int CORNER_W = 12;
    localparam int SLOT_W   = 13;
    localparam int STAT_W   = 2;
    localparam int NORM_W   = 16;
    localparam int SHARE_W  = 14;
    localparam int SUM_W    = 28;

    localparam int DIFF_W   = 31;
    localparam int PROD_W   = 62;
    localparam int MAG_W    = 61;
    localparam int ROOT_W   = 44;
    localparam int LEN_W    = 21;
    localparam int DNUM_W   = 35;
    localparam int QUO_W    = 16;
    localparam int REM_W    = LEN_W + 1;

    localparam logic [QUO_W-1:0] ONE_Q14 = 16'd16384;

    localparam logic [FUNC_W-1:0] FN_LOAD_VTX  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_FACE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_COMPUTE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ_VTX  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_FACE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_EMIT   = 22'h000002,
        S_CLR    = 22'h000004,
        S_FC     = 22'h000008,
        S_FCW    = 22'h000010,
        S_VRD    = 22'h000020,
        S_VLAT   = 22'h000040,
        S_DIFF   = 22'h000080,
        S_MUL    = 22'h000100,
        S_MAG    = 22'h000200,
        S_NORM   = 22'h000400,
        S_SQ     = 22'h000800,
        S_SQRT   = 22'h001000,
        S_DIVLD  = 22'h002000,
        S_DIVRUN = 22'h004000,
        S_WRN    = 22'h008000,
        S_ARD    = 22'h010000,
        S_AWR    = 22'h020000,
        S_RVA    = 22'h040000,
        S_RVW    = 22'h080000,
        S_RFA    = 22'h100000,
        S_RFW    = 22'h200000
    } state_t;

endpackage

[hw/rtl/mesh_vertex_normal_averager.sv]
// Mesh vertex normal averager: vertex/face stores, face normal engine, vertex averages.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, func, coord_*, corner_*, slot | to block
//  out     | out_valid, out_stall, status, norm_*, faces_sharing | from block
//
// Load, clear and rejected items only report a status. Read vertex runs three
// divides in the shared divider, skipped for an untouched vertex. Compute first
// clears the sum memory, then works each face with the one shared multiplier,
// the one-bit-a-cycle normalize shifter, the 22-step root and the three 16-step
// divides (a degenerate face skips all but the multiplier). One item is
// worked at a time; in_stall is high whenever the engine is busy. A finished
// result waits in the output register while the next item is taken. Reset
// clears counts and control only.
module mesh_vertex_normal_averager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mva_pkg::FUNC_W-1:0]          func,
    input  logic signed [mva_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [mva_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [mva_pkg::COORD_W-1:0]  coord_z,
    input  logic [mva_pkg::CORNER_W-1:0]        corner_a,
    input  logic [mva_pkg::CORNER_W-1:0]        corner_b,
    input  logic [mva_pkg::CORNER_W-1:0]        corner_c,
    input  logic [mva_pkg::SLOT_W-1:0]          slot,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mva_pkg::STAT_W-1:0]          status,
    output logic signed [mva_pkg::NORM_W-1:0]   norm_x,
    output logic signed [mva_pkg::NORM_W-1:0]   norm_y,
    output logic signed [mva_pkg::NORM_W-1:0]   norm_z,
    output logic [mva_pkg::SHARE_W-1:0]         faces_sharing
);
    import mva_pkg::*;

    localparam int VTX_MW = 3 * COORD_W;
    localparam int COR_MW = 3 * CORNER_W;
    localparam int FN_MW  = 3 * NORM_W;
    localparam int SUM_MW = 3 * SUM_W + SHARE_W;

    // memories
    logic [VTX_MW-1:0] vtx_mem [MAX_VERTICES];
    logic [COR_MW-1:0] cor_mem [MAX_FACES];
    logic [FN_MW-1:0]  fn_mem  [MAX_FACES];
    logic [SUM_MW-1:0] sum_mem [MAX_VERTICES];

    logic [VTX_MW-1:0] vtx_rdata_reg;
    logic [COR_MW-1:0] cor_rdata_reg;
    logic [FN_MW-1:0]  fn_rdata_reg;
    logic [SUM_MW-1:0] sum_rdata_reg;

    logic              vtx_we, cor_we, fn_we, sum_we;
    logic [VIDX_W-1:0] vtx_raddr, sum_waddr, sum_raddr;
    logic [SUM_MW-1:0] sum_wdata;

    // control
    state_t              state_reg;
    logic [VCNT_W-1:0]   vcount_reg, limit_reg, clr_idx_reg;
    logic [FCNT_W-1:0]   fcount_reg;
    logic [FIDX_W-1:0]   face_idx_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          comp_reg;
    logic                is_vtx_reg;
    logic                out_valid_reg;

    // datapath
    logic [SLOT_W-1:0]          slot_reg;
    logic [CORNER_W-1:0]        cor_reg [3];
    logic signed [COORD_W-1:0]  px_reg [3], py_reg [3], pz_reg [3];
    logic signed [DIFF_W-1:0]   d_reg [6];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   r_reg [3];
    logic [MAG_W-1:0]           mg_reg [3];
    logic [2:0]                 sign_reg;
    logic [ROOT_W-1:0]          sq_reg, rx_reg, rres_reg, rbit_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [REM_W-1:0]           div_rem_reg;
    logic [QUO_W-1:0]           div_lo_reg, div_q_reg;
    logic [LEN_W-1:0]           div_den_reg;
    logic signed [NORM_W-1:0]   n_reg [3];
    logic signed [SUM_W-1:0]    vs_reg [3];
    logic [SHARE_W-1:0]         vcnt_reg;
    logic [STAT_W-1:0]          res_status_reg;
    logic signed [NORM_W-1:0]   res_n_reg [3];
    logic [SHARE_W-1:0]         res_share_reg;
    logic [STAT_W-1:0]          out_status_reg;
    logic signed [NORM_W-1:0]   out_n_reg [3];
    logic [SHARE_W-1:0]         out_share_reg;

    logic in_fire, emit_go, corners_ok, last_face, acc_skip;
    logic signed [DIFF_W-1:0] d_new [6];
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic [MAG_W-1:0]  mg_or;
    logic [ROOT_W-1:0] rt_t, rt_x_next, rt_res_next;
    logic              rt_ge;
    logic [REM_W-1:0]  dv_rem2;
    logic              dv_ge;
    logic [QUO_W-1:0]  dv_q, dv_qc;
    logic signed [NORM_W-1:0] dv_n;
    logic [DNUM_W-1:0] dv_num;
    logic [SUM_W-1:0]  vs_mag;

    function automatic logic signed [DIFF_W-1:0] trunc_sh(
        input logic signed [COORD_W:0] v,
        input logic [1:0]              k
    );
        logic [COORD_W:0]   m;
        logic [COORD_W:0]   s;
        logic [DIFF_W-1:0]  t;
        m = v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
        s = m >> k;
        t = s[DIFF_W-1:0];
        return v[COORD_W] ? $signed(-t) : $signed(t);
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && (state_reg == S_IDLE);
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign norm_x    = out_n_reg[0];
    assign norm_y    = out_n_reg[1];
    assign norm_z    = out_n_reg[2];
    assign faces_sharing = out_share_reg;

    assign corners_ok = ({1'b0, corner_a} < vcount_reg) && ({1'b0, corner_b} < vcount_reg)
                     && ({1'b0, corner_c} < vcount_reg);
    assign last_face  = (FCNT_W'(face_idx_reg) + FCNT_W'(1)) == fcount_reg;

    // a face counts once for a vertex named twice
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    acc_skip = 1'b0;
            2'd1:    acc_skip = (cor_reg[1] == cor_reg[0]);
            default: acc_skip = (cor_reg[2] == cor_reg[0]) || (cor_reg[2] == cor_reg[1]);
        endcase
    end

    // edge vectors, pre-shifted so every magnitude is below 2^30
    always_comb
    begin
        logic signed [COORD_W:0] df [6];
        logic [COORD_W:0]        mo;
        logic [1:0]              k;
        df[0] = {px_reg[2][COORD_W-1], px_reg[2]} - {px_reg[1][COORD_W-1], px_reg[1]};
        df[1] = {py_reg[2][COORD_W-1], py_reg[2]} - {py_reg[1][COORD_W-1], py_reg[1]};
        df[2] = {pz_reg[2][COORD_W-1], pz_reg[2]} - {pz_reg[1][COORD_W-1], pz_reg[1]};
        df[3] = {px_reg[0][COORD_W-1], px_reg[0]} - {px_reg[1][COORD_W-1], px_reg[1]};
        df[4] = {py_reg[0][COORD_W-1], py_reg[0]} - {py_reg[1][COORD_W-1], py_reg[1]};
        df[5] = {pz_reg[0][COORD_W-1], pz_reg[0]} - {pz_reg[1][COORD_W-1], pz_reg[1]};
        mo = '0;
        for (int i = 0; i < 6; i++)
        begin
            mo = mo | (df[i][COORD_W] ? (COORD_W+1)'(-df[i]) : (COORD_W+1)'(df[i]));
        end
        priority if (mo[32])
            k = 2'd3;
        else if (mo[31])
            k = 2'd2;
        else if (mo[30])
            k = 2'd1;
        else
            k = 2'd0;
        for (int i = 0; i < 6; i++)
        begin
            d_new[i] = trunc_sh(df[i], k);
        end
    end

    // shared multiplier operands: cross product terms, then squares
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ)
        begin
            unique case (cnt_reg[1:0])
                2'd0:    mul_a = $signed(DIFF_W'(mg_reg[0][19:0]));
                2'd1:    mul_a = $signed(DIFF_W'(mg_reg[1][19:0]));
                default: mul_a = $signed(DIFF_W'(mg_reg[2][19:0]));
            endcase
            mul_b = mul_a;
        end
        else
        begin
            unique case (cnt_reg[2:0])
                3'd0:    begin mul_a = d_reg[1]; mul_b = d_reg[5]; end
                3'd1:    begin mul_a = d_reg[2]; mul_b = d_reg[4]; end
                3'd2:    begin mul_a = d_reg[2]; mul_b = d_reg[3]; end
                3'd3:    begin mul_a = d_reg[0]; mul_b = d_reg[5]; end
                3'd4:    begin mul_a = d_reg[0]; mul_b = d_reg[4]; end
                default: begin mul_a = d_reg[1]; mul_b = d_reg[3]; end
            endcase
        end
    end

    assign mg_or = mg_reg[0] | mg_reg[1] | mg_reg[2];

    // one digit of the integer square root
    assign rt_t        = rres_reg + rbit_reg;
    assign rt_ge       = rx_reg >= rt_t;
    assign rt_x_next   = rt_ge ? rx_reg - rt_t : rx_reg;
    assign rt_res_next = rt_ge ? (rres_reg >> 1) + rbit_reg : rres_reg >> 1;

    // one bit of the restoring divider
    assign dv_rem2 = {div_rem_reg[REM_W-2:0], div_lo_reg[QUO_W-1]};
    assign dv_ge   = dv_rem2 >= {1'b0, div_den_reg};
    assign dv_q    = {div_q_reg[QUO_W-2:0], dv_ge};
    assign dv_qc   = (dv_q > ONE_Q14) ? ONE_Q14 : dv_q;
    assign dv_n    = sign_reg[comp_reg] ? $signed(-dv_qc) : $signed(dv_qc);

    assign vs_mag  = vs_reg[comp_reg][SUM_W-1] ? SUM_W'(-vs_reg[comp_reg])
                                               : SUM_W'(vs_reg[comp_reg]);
    assign dv_num  = is_vtx_reg
                   ? DNUM_W'(vs_mag) + DNUM_W'(vcnt_reg >> 1)
                   : {1'b0, mg_reg[comp_reg][19:0], 14'd0} + DNUM_W'(len_reg >> 1);

    // memory ports
    assign vtx_we = in_fire && (func == FN_LOAD_VTX) && (vcount_reg < VCNT_W'(MAX_VERTICES));
    assign cor_we = in_fire && (func == FN_LOAD_FACE) && (fcount_reg < FCNT_W'(MAX_FACES))
                 && corners_ok;
    assign fn_we  = (state_reg == S_WRN);
    assign sum_we = (state_reg == S_CLR) || (state_reg == S_AWR);
    assign vtx_raddr = cor_reg[cnt_reg[1:0]][VIDX_W-1:0];
    assign sum_raddr = (state_reg == S_RVA) ? slot_reg[VIDX_W-1:0]
                                            : cor_reg[comp_reg][VIDX_W-1:0];
    assign sum_waddr = (state_reg == S_CLR) ? clr_idx_reg[VIDX_W-1:0]
                                            : cor_reg[comp_reg][VIDX_W-1:0];

    always_comb
    begin
        logic signed [SUM_W-1:0] sx, sy, sz;
        logic [SHARE_W-1:0]      sc;
        sx = sum_rdata_reg[SUM_W-1:0];
        sy = sum_rdata_reg[2*SUM_W-1:SUM_W];
        sz = sum_rdata_reg[3*SUM_W-1:2*SUM_W];
        sc = sum_rdata_reg[SUM_MW-1:3*SUM_W];
        if (state_reg == S_CLR)
            sum_wdata = '0;
        else
            sum_wdata = {sc + SHARE_W'(1),
                         sz + SUM_W'(n_reg[2]), sy + SUM_W'(n_reg[1]), sx + SUM_W'(n_reg[0])};
    end

    always_ff @(posedge clk)
    begin
        if (vtx_we)
            vtx_mem[vcount_reg[VIDX_W-1:0]] <= {coord_z, coord_y, coord_x};
        vtx_rdata_reg <= vtx_mem[vtx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cor_we)
            cor_mem[fcount_reg[FIDX_W-1:0]] <= {corner_c, corner_b, corner_a};
        cor_rdata_reg <= cor_mem[face_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fn_we)
            fn_mem[face_idx_reg] <= {n_reg[2], n_reg[1], n_reg[0]};
        fn_rdata_reg <= fn_mem[slot_reg[FIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            fcount_reg    <= '0;
            limit_reg     <= '0;
            clr_idx_reg   <= '0;
            face_idx_reg  <= '0;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            is_vtx_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        is_vtx_reg <= (func == FN_READ_VTX);
                        face_idx_reg <= '0;
                        clr_idx_reg <= '0;
                        unique case (func)
                            FN_LOAD_VTX:
                            begin
                                if (vcount_reg < VCNT_W'(MAX_VERTICES))
                                    vcount_reg <= vcount_reg + VCNT_W'(1);
                                state_reg <= S_EMIT;
                            end
                            FN_LOAD_FACE:
                            begin
                                if (cor_we)
                                    fcount_reg <= fcount_reg + FCNT_W'(1);
                                state_reg <= S_EMIT;
                            end
                            FN_COMPUTE:
                            begin
                                limit_reg <= vcount_reg;
                                if (vcount_reg != '0)
                                    state_reg <= S_CLR;
                                else if (fcount_reg != '0)
                                    state_reg <= S_FC;
                                else
                                    state_reg <= S_EMIT;
                            end
                            FN_READ_VTX:
                            begin
                                if (slot >= vcount_reg || slot >= limit_reg)
                                    state_reg <= S_EMIT;
                                else
                                    state_reg <= S_RVA;
                            end
                            FN_READ_FACE:
                            begin
                                if ({1'b0, slot} >= fcount_reg)
                                    state_reg <= S_EMIT;
                                else
                                    state_reg <= S_RFA;
                            end
                            FN_CLEAR:
                            begin
                                vcount_reg <= '0;
                                fcount_reg <= '0;
                                limit_reg  <= '0;
                                state_reg  <= S_EMIT;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                        state_reg <= S_IDLE;
                end
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + VCNT_W'(1);
                    if (clr_idx_reg + VCNT_W'(1) == vcount_reg)
                        state_reg <= (fcount_reg != '0) ? S_FC : S_EMIT;
                end
                S_FC:
                    state_reg <= S_FCW;
                S_FCW:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_VRD;
                end
                S_VRD:
                    state_reg <= S_VLAT;
                S_VLAT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    state_reg <= (cnt_reg == 5'd2) ? S_DIFF : S_VRD;
                end
                S_DIFF:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd6)
                        state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    if (r_reg[0] == '0 && r_reg[1] == '0 && r_reg[2] == '0)
                        state_reg <= S_WRN;
                    else
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    cnt_reg <= '0;
                    if (mg_or[MAG_W-1:20] == '0 && mg_or[19])
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd21)
                    begin
                        comp_reg  <= '0;
                        state_reg <= S_DIVLD;
                    end
                end
                S_DIVLD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVRUN;
                end
                S_DIVRUN:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        if (comp_reg == 2'd2)
                            state_reg <= is_vtx_reg ? S_EMIT : S_WRN;
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= S_DIVLD;
                        end
                    end
                end
                S_WRN:
                begin
                    comp_reg  <= '0;
                    state_reg <= S_ARD;
                end
                S_ARD, S_AWR:
                begin
                    if (state_reg == S_ARD && !acc_skip)
                        state_reg <= S_AWR;
                    else if (comp_reg != 2'd2)
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_ARD;
                    end
                    else if (last_face)
                        state_reg <= S_EMIT;
                    else
                    begin
                        face_idx_reg <= face_idx_reg + FIDX_W'(1);
                        state_reg    <= S_FC;
                    end
                end
                S_RVA:
                    state_reg <= S_RVW;
                S_RVW:
                begin
                    comp_reg <= '0;
                    if (sum_rdata_reg[SUM_MW-1:3*SUM_W] == '0)
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_DIVLD;
                end
                S_RFA:
                    state_reg <= S_RFW;
                S_RFW:
                    state_reg <= S_EMIT;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_status_reg <= res_status_reg;
            out_n_reg      <= res_n_reg;
            out_share_reg  <= res_share_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    slot_reg      <= slot;
                    res_n_reg[0]  <= '0;
                    res_n_reg[1]  <= '0;
                    res_n_reg[2]  <= '0;
                    res_share_reg <= '0;
                    res_status_reg <= ST_OK;
                    unique case (func)
                        FN_LOAD_VTX:
                            if (vcount_reg >= VCNT_W'(MAX_VERTICES))
                                res_status_reg <= ST_FULL;
                        FN_LOAD_FACE:
                        begin
                            if (fcount_reg >= FCNT_W'(MAX_FACES))
                                res_status_reg <= ST_FULL;
                            else if (!corners_ok)
                                res_status_reg <= ST_RANGE;
                        end
                        FN_COMPUTE:
                            res_share_reg <= fcount_reg;
                        FN_READ_VTX:
                        begin
                            if (slot >= vcount_reg)
                                res_status_reg <= ST_RANGE;
                            else if (slot >= limit_reg)
                                res_status_reg <= ST_ZERO;
                        end
                        FN_READ_FACE:
                            if ({1'b0, slot} >= fcount_reg)
                                res_status_reg <= ST_RANGE;
                        default:
                            res_status_reg <= ST_OK;
                    endcase
                end
            end
            S_FCW:
            begin
                cor_reg[0] <= cor_rdata_reg[CORNER_W-1:0];
                cor_reg[1] <= cor_rdata_reg[2*CORNER_W-1:CORNER_W];
                cor_reg[2] <= cor_rdata_reg[3*CORNER_W-1:2*CORNER_W];
            end
            S_VLAT:
            begin
                px_reg[cnt_reg[1:0]] <= vtx_rdata_reg[COORD_W-1:0];
                py_reg[cnt_reg[1:0]] <= vtx_rdata_reg[2*COORD_W-1:COORD_W];
                pz_reg[cnt_reg[1:0]] <= vtx_rdata_reg[3*COORD_W-1:2*COORD_W];
            end
            S_DIFF:
                d_reg <= d_new;
            S_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                // product of step n-1 folds into component (n-1)/2
                if (cnt_reg != 5'd0)
                begin
                    if (cnt_reg[0])
                        r_reg[2'((cnt_reg - 5'd1) >> 1)] <= prod_reg;
                    else
                        r_reg[2'((cnt_reg - 5'd1) >> 1)] <=
                            r_reg[2'((cnt_reg - 5'd1) >> 1)] - prod_reg;
                end
            end
            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sign_reg[i] <= r_reg[i][PROD_W-1];
                    mg_reg[i]   <= r_reg[i][PROD_W-1] ? MAG_W'(-r_reg[i]) : MAG_W'(r_reg[i]);
                    n_reg[i]    <= '0;
                end
            end
            S_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mg_or[MAG_W-1:20] != '0)
                        mg_reg[i] <= mg_reg[i] >> 1;
                    else if (!mg_or[19])
                        mg_reg[i] <= mg_reg[i] << 1;
                end
            end
            S_SQ:
            begin
                prod_reg <= mul_a * mul_b;
                if (cnt_reg == 5'd1)
                    sq_reg <= ROOT_W'(prod_reg);
                else if (cnt_reg == 5'd2)
                    sq_reg <= sq_reg + ROOT_W'(prod_reg);
                else if (cnt_reg == 5'd3)
                begin
                    rx_reg   <= sq_reg + ROOT_W'(prod_reg);
                    rres_reg <= '0;
                    rbit_reg <= ROOT_W'(1) << 42;
                end
            end
            S_SQRT:
            begin
                rx_reg   <= rt_x_next;
                rres_reg <= rt_res_next;
                rbit_reg <= rbit_reg >> 2;
                if (cnt_reg == 5'd21)
                    len_reg <= rt_res_next[LEN_W-1:0];
            end
            S_DIVLD:
            begin
                div_rem_reg <= REM_W'(dv_num[DNUM_W-1:QUO_W]);
                div_lo_reg  <= dv_num[QUO_W-1:0];
                div_q_reg   <= '0;
                div_den_reg <= is_vtx_reg ? LEN_W'(vcnt_reg) : len_reg;
            end
            S_DIVRUN:
            begin
                div_rem_reg <= dv_ge ? dv_rem2 - {1'b0, div_den_reg} : dv_rem2;
                div_lo_reg  <= div_lo_reg << 1;
                div_q_reg   <= dv_q;
                if (cnt_reg == 5'd15)
                begin
                    n_reg[comp_reg] <= dv_n;
                    if (is_vtx_reg)
                        res_n_reg[comp_reg] <= dv_n;
                end
            end
            S_RVW:
            begin
                vs_reg[0] <= sum_rdata_reg[SUM_W-1:0];
                vs_reg[1] <= sum_rdata_reg[2*SUM_W-1:SUM_W];
                vs_reg[2] <= sum_rdata_reg[3*SUM_W-1:2*SUM_W];
                vcnt_reg  <= sum_rdata_reg[SUM_MW-1:3*SUM_W];
                sign_reg  <= {sum_rdata_reg[3*SUM_W-1], sum_rdata_reg[2*SUM_W-1],
                              sum_rdata_reg[SUM_W-1]};
                res_share_reg <= sum_rdata_reg[SUM_MW-1:3*SUM_W];
                if (sum_rdata_reg[SUM_MW-1:3*SUM_W] == '0)
                    res_status_reg <= ST_ZERO;
            end
            S_RFW:
            begin
                res_n_reg[0] <= fn_rdata_reg[NORM_W-1:0];
                res_n_reg[1] <= fn_rdata_reg[2*NORM_W-1:NORM_W];
                res_n_reg[2] <= fn_rdata_reg[3*NORM_W-1:2*NORM_W];
                if (fn_rdata_reg == '0)
                    res_status_reg <= ST_ZERO;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_vcount_max: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count above store size");

    a_limit_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= vcount_reg)
        else $error("computed range beyond loaded vertices");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVRUN |-> div_rem_reg < {1'b0, div_den_reg})
        else $error("divider remainder not below divisor");

    a_face_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FC |-> FCNT_W'(face_idx_reg) < fcount_reg)
        else $error("face walk past face count");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && out_stall) |=> state_reg == S_EMIT)
        else $error("result dropped while output stalled");
`endif

endmodule
